### sv/shtq_pkg.sv
// Shared constants for the string hash table with triangular probing.
`default_nettype none
package shtq_pkg;
	localparam logic       CMD_INSERT  = 1'b0;
	localparam logic       CMD_SEARCH  = 1'b1;
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TOOLONG  = 3'd4;
	localparam logic       REG_MULT    = 1'b0;
	localparam logic       REG_SIZE    = 1'b1;
	localparam int         HASH_W      = 32;
endpackage
`default_nettype wire

### sv/string_hash_table_quadratic_probe.sv
// Top level of the string hash table with open addressing and triangular probing.
`default_nettype none
// Keys arrive one byte per transfer on the slave stream, the key's final byte
// marked by s_tlast; s_tuser on the first byte selects insert or search. The
// front end takes one byte per cycle while the queue is not full, folding it into
// a 32-bit polynomial hash, and hands each finished key to a two-entry queue so it
// can keep taking bytes while the back end works. The back end reduces the hash
// modulo the live table size with a one-bit-per-cycle remainder unit, then walks
// the probe sequence home + i(i+1)/2: an insert tests each probe in the probe
// state, a search passes probe and compare states per probe (slot-store read,
// then compare). Over-long keys skip the reduction and the walk. Each key gives
// exactly one result transfer on the master stream. Occupancy bits clear at
// reset, so no clearing pass is needed. The user must write configuration
// (multiplier, table size) only while idle; the block does not enforce it.
module string_hash_table_quadratic_probe import shtq_pkg::*; #(
	parameter int SLOTS   = 256,
	parameter int MAX_LEN = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
	input  wire logic        s_tlast,   // last_byte
	input  wire logic [0:0]  s_tuser,   // [0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] slot_index, [10:8] status, rest zero
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int SW = $clog2(SLOTS + 1);
	localparam int JW = 2 + LW + HASH_W + MAX_LEN * 8;

	logic [31:0]   mult_q;
	logic [8:0]    tsize_q;
	logic [SW-1:0] live_size;
	logic          job_push;
	logic          job_pop;
	logic          job_empty;
	logic          job_full;
	logic [JW-1:0] job_in;
	logic [JW-1:0] job_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q  <= 32'd31;
			tsize_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MULT: mult_q  <= cfg_wdata;
				REG_SIZE: tsize_q <= cfg_wdata[8:0];
				default:  mult_q  <= mult_q;
			endcase
		end
	end

	// A size of zero acts as one; a size beyond the store acts as the store.
	always_comb begin
		if (tsize_q == 9'd0) begin
			live_size = SW'(1);
		end else if (32'(tsize_q) > 32'(SLOTS)) begin
			live_size = SW'(SLOTS);
		end else begin
			live_size = SW'(tsize_q);
		end
	end

	shtq_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .mult(mult_q),
		.byte_valid(s_tvalid), .byte_ready(s_tready), .key_byte(s_tdata),
		.command(s_tuser[0]), .last_byte(s_tlast),
		.job_push(job_push), .job_data(job_in), .job_full(job_full)
	);

	shtq_queue #(.WIDTH(JW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(job_push), .wdata(job_in),
		.pop(job_pop), .rdata(job_out), .empty(job_empty), .full(job_full)
	);

	shtq_back #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .size(live_size),
		.job_data(job_out), .job_empty(job_empty), .job_pop(job_pop),
		.res_valid(m_tvalid), .res_ready(m_tready), .res_data(m_tdata)
	);
endmodule
`default_nettype wire

### sv/shtq_front.sv
// Front end: gathers key bytes, folds the hash and emits one job per key.
`default_nettype none
module shtq_front import shtq_pkg::*; #(
	parameter int MAX_LEN = 20,
	parameter int LW      = $clog2(MAX_LEN + 1),
	parameter int JW      = 2 + LW + HASH_W + MAX_LEN * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   mult,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire logic [7:0]    key_byte,
	input  wire logic          command,
	input  wire logic          last_byte,
	output logic               job_push,
	output logic [JW-1:0]      job_data,
	input  wire logic          job_full
);
	logic [7:0]        key_q [MAX_LEN];
	logic [LW-1:0]     len_q;
	logic [HASH_W-1:0] hash_q;
	logic              ovl_q;
	logic              cmd_q;
	logic              take;
	logic              room;
	logic [LW-1:0]     len_nx;
	logic [HASH_W-1:0] hash_nx;
	logic              ovl_nx;
	logic              cmd_nx;
	logic [MAX_LEN*8-1:0] key_flat;

	assign byte_ready = !job_full;
	assign take       = byte_valid && byte_ready;
	assign room       = len_q < LW'(MAX_LEN);

	always_comb begin
		cmd_nx  = (len_q == '0 && !ovl_q) ? command : cmd_q;
		len_nx  = room ? len_q + LW'(1) : len_q;
		ovl_nx  = ovl_q || !room;
		hash_nx = room ? HASH_W'(hash_q * mult + {{24{key_byte[7]}}, key_byte}) : hash_q;
		for (int k = 0; k < MAX_LEN; k++) begin
			key_flat[k*8 +: 8] = (room && len_q == LW'(k)) ? key_byte : key_q[k];
		end
	end

	assign job_push = take && last_byte;
	assign job_data = {cmd_nx, ovl_nx, len_nx, hash_nx, key_flat};

	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				key_q[k] <= key_flat[k*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			hash_q <= '0;
			ovl_q  <= 1'b0;
			cmd_q  <= CMD_INSERT;
		end else if (take) begin
			cmd_q <= cmd_nx;
			if (last_byte) begin
				len_q  <= '0;
				hash_q <= '0;
				ovl_q  <= 1'b0;
			end else begin
				len_q  <= len_nx;
				hash_q <= hash_nx;
				ovl_q  <= ovl_nx;
			end
		end
	end
endmodule
`default_nettype wire

### sv/shtq_queue.sv
// Two-entry job queue between front end and back end.
`default_nettype none
module shtq_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output logic                  full
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

### sv/shtq_back.sv
// Back end: reduces the hash, walks the probe sequence and owns the slot store.
`default_nettype none
module shtq_back import shtq_pkg::*; #(
	parameter int SLOTS   = 256,
	parameter int MAX_LEN = 20,
	parameter int LW      = $clog2(MAX_LEN + 1),
	parameter int SW      = $clog2(SLOTS + 1),
	parameter int AW      = $clog2(SLOTS),
	parameter int JW      = 2 + LW + HASH_W + MAX_LEN * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [SW-1:0] size,
	input  wire logic [JW-1:0] job_data,
	input  wire logic          job_empty,
	output logic               job_pop,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [15:0]        res_data
);
	typedef enum logic [2:0] {B_IDLE, B_DIV, B_PROBE, B_CMP, B_RESP} bstate_t;

	localparam int KB = MAX_LEN * 8;

	bstate_t           state_q;
	logic [KB-1:0]     key_q;
	logic [HASH_W-1:0] hash_q;
	logic [LW-1:0]     len_q;
	logic              cmd_q;
	logic [SW-1:0]     rem_q;
	logic [4:0]        cnt_q;
	logic [AW-1:0]     s_q;
	logic [SW-1:0]     i_q;
	logic [2:0]        st_q;
	logic [7:0]        slot_q;
	logic              used_q [SLOTS];
	logic [KB-1:0]     kmem [SLOTS];
	logic [LW-1:0]     lmem [SLOTS];
	logic [KB-1:0]     krd_q;
	logic [LW-1:0]     lrd_q;
	logic              out_v_q;
	logic [15:0]       out_d_q;

	logic [SW:0]       div_t;
	logic [SW-1:0]     rem_nx;
	logic [SW-1:0]     i_nx;
	logic [SW:0]       sum;
	logic [AW-1:0]     s_nx;
	logic              walk_end;
	logic              match;
	logic              ins_hit;
	logic [31:0]       s_wide;

	assign job_pop   = state_q == B_IDLE && !job_empty;
	assign res_valid = out_v_q;
	assign res_data  = out_d_q;

	always_comb begin
		div_t    = {rem_q, hash_q[HASH_W-1]};
		rem_nx   = (div_t >= (SW+1)'(size)) ? SW'(div_t - (SW+1)'(size)) : SW'(div_t);
		i_nx     = i_q + SW'(1);
		walk_end = i_nx == size;
		sum      = (SW+1)'(s_q) + (SW+1)'(i_nx);
		s_nx     = (sum >= (SW+1)'(size)) ? AW'(sum - (SW+1)'(size)) : AW'(sum);
		ins_hit  = !used_q[s_q];
		s_wide   = 32'(s_q);
		match    = used_q[s_q] && lrd_q == len_q;
		for (int k = 0; k < MAX_LEN; k++) begin
			if (LW'(k) < len_q && krd_q[k*8 +: 8] != key_q[k*8 +: 8]) match = 1'b0;
		end
	end

	// Slot store: one key row and one length per slot.
	always_ff @(posedge clk) begin
		if (state_q == B_PROBE && cmd_q == CMD_INSERT && ins_hit) begin
			kmem[s_q] <= key_q;
			lmem[s_q] <= len_q;
		end
		krd_q <= kmem[s_q];
		lrd_q <= lmem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
			for (int k = 0; k < SLOTS; k++) used_q[k] <= 1'b0;
		end else begin
			// In the response state the output register is handled below.
			if (out_v_q && res_ready && state_q != B_RESP) out_v_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						{cmd_q, len_q, hash_q, key_q} <= {job_data[JW-1],
							job_data[JW-3:0]};
						rem_q  <= '0;
						cnt_q  <= '0;
						i_q    <= '0;
						slot_q <= '0;
						if (job_data[JW-2]) begin
							st_q    <= ST_TOOLONG;
							state_q <= B_RESP;
						end else begin
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					rem_q  <= rem_nx;
					hash_q <= hash_q << 1;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						s_q     <= AW'(rem_nx);
						state_q <= B_PROBE;
					end
				end
				B_PROBE: begin
					if (cmd_q == CMD_SEARCH) begin
						state_q <= B_CMP;
					end else if (ins_hit) begin
						used_q[s_q] <= 1'b1;
						slot_q      <= s_wide[7:0];
						st_q        <= ST_INSERTED;
						state_q     <= B_RESP;
					end else if (walk_end) begin
						st_q    <= ST_FULL;
						state_q <= B_RESP;
					end else begin
						i_q <= i_nx;
						s_q <= s_nx;
					end
				end
				B_CMP: begin
					if (match) begin
						slot_q  <= s_wide[7:0];
						st_q    <= ST_FOUND;
						state_q <= B_RESP;
					end else if (walk_end) begin
						st_q    <= ST_NOTFOUND;
						state_q <= B_RESP;
					end else begin
						i_q     <= i_nx;
						s_q     <= s_nx;
						state_q <= B_PROBE;
					end
				end
				B_RESP: begin
					if (!out_v_q || res_ready) begin
						out_v_q <= 1'b1;
						out_d_q <= {5'd0, st_q, slot_q};
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_PROBE |-> (SW+1)'(s_q) < (SW+1)'(size))
		else $error("probe slot outside live table");
	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CMP |-> $past(state_q) == B_PROBE)
		else $error("compare without a slot read");
	a_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_d_q[10:8] != ST_INSERTED && out_d_q[10:8] != ST_FOUND
		|-> out_d_q[7:0] == 8'd0)
		else $error("nonzero slot on failure result");
endmodule
`default_nettype wire

### tb/string_hash_table_quadratic_probe_tb.sv
// Testbench for the string hash table with triangular probing: directed and random keys, self-checking.
`default_nettype none

module string_hash_table_quadratic_probe_tb import shtq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 256;
	localparam int KEY_MAX = 20;
	// Slowest result: hash reduction plus a full search walk through probe and compare states per probe,
	// with the receiver stalling most of the time on top of it.
	localparam int SETTLE_CYCLES = 700;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef bit [7:0] key_t[$];

	// Table model: tracks the slot store and the key being assembled, and keeps the
	// results it predicts in arrival order for the result checker.
	class hash_table_board;
		bit [31:0] mult = 32'd31;
		bit [8:0] tsize = 9'd256;
		bit occupied[NSLOT];
		bit [7:0] stored_key[NSLOT][KEY_MAX];
		int stored_len[NSLOT];
		bit [7:0] cur_key[KEY_MAX];
		int cur_len;
		bit [31:0] hash_acc;
		bit cur_cmd;
		bit too_long;
		bit [15:0] pending_results[$];
		int errors;

		function int live_size();
			if (tsize == 0) return 1;
			if (tsize > NSLOT) return NSLOT;
			return tsize;
		endfunction

		function bit same_key(int s);
			if (stored_len[s] != cur_len) return 0;
			for (int j = 0; j < cur_len; j++)
				if (stored_key[s][j] != cur_key[j]) return 0;
			return 1;
		endfunction

		// Fold one accepted byte into the key; on the last byte, work out the result.
		function void note_byte(bit cmd, bit [7:0] b, bit last);
			int size;
			longint home;
			int s;
			bit [7:0] slot;
			bit [2:0] st;
			if (cur_len == 0 && !too_long)
				cur_cmd = cmd;
			if (cur_len < KEY_MAX) begin
				cur_key[cur_len] = b;
				cur_len++;
				hash_acc = hash_acc * mult + {{24{b[7]}}, b};
			end else begin
				too_long = 1;
			end
			if (!last) return;
			slot = 0;
			if (too_long) begin
				st = ST_TOOLONG;
			end else begin
				size = live_size();
				home = hash_acc % size;
				st = (cur_cmd == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
				for (longint i = 0; i < size; i++) begin
					s = int'((home + i * (i + 1) / 2) % size);
					if (cur_cmd == CMD_INSERT && !occupied[s]) begin
						occupied[s] = 1;
						for (int j = 0; j < cur_len; j++)
							stored_key[s][j] = cur_key[j];
						stored_len[s] = cur_len;
						slot = s[7:0];
						st = ST_INSERTED;
						break;
					end
					if (cur_cmd == CMD_SEARCH && occupied[s] && same_key(s)) begin
						slot = s[7:0];
						st = ST_FOUND;
						break;
					end
				end
			end
			pending_results.push_back({5'd0, st, slot});
			cur_len = 0;
			hash_acc = 0;
			too_long = 0;
		endfunction

		function void check_result(bit [15:0] got);
			bit [15:0] want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got[7:0] != want[7:0]) begin
				$display("%0t: slot_index mismatch, expected %0d, actual %0d",
					$time, want[7:0], got[7:0]);
				errors++;
			end
			if (got[10:8] != want[10:8]) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want[10:8], got[10:8]);
				errors++;
			end
			if (got[15:11] != want[15:11]) begin
				$display("%0t: padding bits mismatch, expected %h, actual %h",
					$time, want[15:11], got[15:11]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;

	hash_table_board board = new();
	int send_gap_pct;
	int recv_stall_pct;
	longint cycles;
	int bytes_sent;

	string_hash_table_quadratic_probe uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: a transfer is taken on the values seen just before the edge, then
	// tready is redrawn for the next cycle according to the current stall rate.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Drive one byte and hold it until its transfer completes. A gap lowers tvalid
	// first; back-to-back bytes leave tvalid high, so it is never toggled within a step.
	task automatic send_byte(bit cmd, bit [7:0] b, bit last);
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_byte(cmd, b, last);
		bytes_sent++;
	endtask

	// Only the first byte's tuser counts; later bytes carry random noise there.
	task automatic send_key(bit cmd, key_t k);
		for (int j = 0; j < k.size(); j++)
			send_byte(j == 0 ? cmd : 1'($urandom), k[j], j == k.size() - 1);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	// Registers change only with the block idle and every result in.
	task automatic write_reg(logic idx, logic [31:0] v);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MULT) board.mult = v;
		else board.tsize = v[8:0];
	endtask

	function automatic key_t random_key(int len);
		key_t k;
		for (int j = 0; j < len; j++)
			k.push_back(8'($urandom_range(255, 1)));
		return k;
	endfunction

	task automatic random_phase(int quota, bit pause_midway);
		key_t pool[8];
		key_t k;
		int r;
		bit paused;
		// Keys mostly come from a small pool so that searches hit and inserts collide.
		for (int p = 0; p < 8; p++)
			pool[p] = random_key($urandom_range(3) == 0 ?
				$urandom_range(KEY_MAX, 1) : $urandom_range(4, 1));
		pool[7] = random_key(KEY_MAX);
		quota += bytes_sent;
		paused = 0;
		while (bytes_sent < quota) begin
			r = $urandom_range(99);
			if (r < 85) k = pool[$urandom_range(7)];
			else if (r < 95) k = random_key($urandom_range(6, 1));
			else k = random_key($urandom_range(KEY_MAX + 4, KEY_MAX + 1));
			send_key(1'($urandom), k);
			if (pause_midway && !paused && bytes_sent * 2 >= quota) begin
				// Starve the block until its output has fully drained.
				wait_for_results();
				paused = 1;
			end
		end
	endtask

	initial begin
		bit [31:0] mults[6];
		int sizes[6];
		key_t k;
		mults = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd31, $urandom, 32'd1};
		sizes = '{1, 256, 3, 256, 17, 256};
		send_gap_pct = 25;
		recv_stall_pct = 83;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed keys with the reset settings: the bytes 01 and FF, a missing
		// key, a key of exactly the maximum length, an over-long key, a duplicate.
		send_key(CMD_INSERT, '{8'h01});
		send_key(CMD_INSERT, '{8'hFF});
		send_key(CMD_SEARCH, '{8'h01});
		send_key(CMD_SEARCH, '{8'hFF});
		send_key(CMD_SEARCH, '{8'h02});
		k = {};
		for (int j = 0; j < KEY_MAX; j++) k.push_back(j[0] ? 8'h7F : 8'h80);
		send_key(CMD_INSERT, k);
		k.push_back(8'h55);
		send_key(CMD_SEARCH, k);
		send_key(CMD_INSERT, '{8'h01});
		send_key(CMD_SEARCH, '{8'h01});

		// Six settings, two per idling mode; the one-slot table exercises a full table.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_MULT, mults[ph]);
			write_reg(REG_SIZE, 32'(sizes[ph]));
			send_gap_pct = (ph < 2) ? 25 : (ph < 4) ? 83 : 0;
			recv_stall_pct = (ph < 2) ? 83 : (ph < 4) ? 25 : 0;
			random_phase(160, ph == 3);
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

`default_nettype wire
